// ===== design/adc_differential_averaging_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ADC differential averaging sequencer - assertion macros
// Concurrent assertion helpers used by the sequencer accumulate stage.
// ----------------------------------------------------------------------------
`ifndef ADC_DIFFERENTIAL_AVERAGING_SEQUENCER_UNIT_MACROS_SVH
`define ADC_DIFFERENTIAL_AVERAGING_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define ADAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ADAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ADAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ADAS_ASSERT(lbl, clk, rstn, prop, msg)
`define ADAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ADAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/adas_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC differential averaging sequencer - package
// Shared codes, types and default sizes.
// ----------------------------------------------------------------------------
package adas_pkg;

    // Default configuration
    localparam int DEF_SAMPLES     = 4;
    localparam int DEF_SAMPLE_BITS = 10;

    // Fixed field widths
    localparam int OP_W         = 2;
    localparam int SAMPLE_W     = 10;
    localparam int VALUE_W      = 14;
    localparam int OFFSET_OUT_W = 10;
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 16;

    // Headroom of the running sum over the sample width
    localparam int ACC_GUARD_W = 6;

    // Measurement scaling: multiply by 4 (shift), then divide by ScaleDen
    localparam int SCALE_SHIFT = 2;
    localparam int ScaleDen    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_START_ALT = 2'd1,
        OP_START_GAIN = 2'd2,
        OP_STOP      = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_ALT       = 6'b000010,
        PH_CAL_SKIP  = 6'b000100,
        PH_CAL       = 6'b001000,
        PH_MEAS_SKIP = 6'b010000,
        PH_MEAS      = 6'b100000
    } phase_t;

    // What a finished round sum stands for
    typedef enum logic [1:0] {
        RES_ALT  = 2'd0,
        RES_CAL  = 2'd1,
        RES_MEAS = 2'd2
    } res_mode_t;

endpackage

// ===== design/adas_accum.sv =====
// ----------------------------------------------------------------------------
// ADC differential averaging sequencer - accumulate stage
// Mode sequencing, sample counting and the running sum; hands finished
// round sums to the scaling pipeline.
// ----------------------------------------------------------------------------
`include "adc_differential_averaging_sequencer_unit_macros.svh"

module adas_accum import adas_pkg::*; #(
    parameter int SAMPLES     = DEF_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int ACC_W      = SAMPLE_BITS + ACC_GUARD_W,
    localparam int CNT_W      = $clog2(SAMPLES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  op_t                           s_op,
    input  logic [SAMPLE_W-1:0]           s_sample,
    input  logic                          p2_ready,
    input  logic                          ofs_wr,
    input  logic signed [SAMPLE_BITS-1:0] ofs_value,
    output logic                          p1_valid,
    output res_mode_t                     p1_mode,
    output logic signed [ACC_W-1:0]       p1_sum
);

    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        count_reg, count_next, count_inc;
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_sum, term;
    logic signed [SAMPLE_BITS-1:0] ofs_reg;
    logic                    p1_valid_reg;
    res_mode_t               p1_mode_reg;
    logic signed [ACC_W-1:0] p1_sum_reg;

    logic [SAMPLE_BITS-1:0]  raw_b;
    logic signed [ACC_W-1:0] raw_u, raw_s, ofs_s;
    logic                    accept, emit;
    res_mode_t               emit_mode;

    assign s_ready = !p1_valid_reg || p2_ready;
    assign accept  = s_valid && s_ready;

    assign raw_b = SAMPLE_BITS'(s_sample);
    assign raw_u = ACC_W'(raw_b);
    assign raw_s = ACC_W'($signed(raw_b));
    assign ofs_s = ACC_W'(ofs_reg);

    // Term added by a sample in the current phase
    always_comb begin
        unique case (phase_reg)
            PH_ALT:  term = count_reg[0] ? raw_u : -raw_u;
            PH_CAL:  term = raw_s;
            PH_MEAS: term = raw_s - ofs_s;
            default: term = '0;
        endcase
    end

    assign acc_sum   = acc_reg + term;
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        emit_mode  = RES_ALT;
        if (accept) begin
            unique case (s_op)
                OP_START_ALT: begin
                    phase_next = PH_ALT;
                    count_next = '0;
                    acc_next   = '0;
                end
                OP_START_GAIN: begin
                    phase_next = PH_CAL_SKIP;
                    count_next = '0;
                    acc_next   = '0;
                end
                OP_STOP: begin
                    phase_next = PH_IDLE;
                end
                OP_SAMPLE: begin
                    unique case (phase_reg)
                        PH_CAL_SKIP: begin
                            phase_next = PH_CAL;
                            count_next = '0;
                            acc_next   = '0;
                        end
                        PH_MEAS_SKIP: begin
                            phase_next = PH_MEAS;
                            count_next = '0;
                            acc_next   = '0;
                        end
                        PH_ALT, PH_CAL, PH_MEAS: begin
                            acc_next   = acc_sum;
                            count_next = count_inc;
                            if (count_inc == CNT_W'(SAMPLES)) begin
                                emit       = 1'b1;
                                count_next = '0;
                                priority if (phase_reg == PH_ALT) begin
                                    emit_mode = RES_ALT;
                                    acc_next  = '0;
                                end else if (phase_reg == PH_CAL) begin
                                    // keep the sum; the skip phase clears it
                                    emit_mode  = RES_CAL;
                                    phase_next = PH_MEAS_SKIP;
                                end else begin
                                    emit_mode = RES_MEAS;
                                    acc_next  = '0;
                                end
                            end
                        end
                        default: begin
                            // idle: drop the sample
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            acc_reg      <= '0;
            ofs_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            if (ofs_wr) begin
                ofs_reg <= ofs_value;
            end
            if (emit) begin
                p1_valid_reg <= 1'b1;
            end else if (p2_ready) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            p1_mode_reg <= emit_mode;
            p1_sum_reg  <= acc_sum;
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1_mode  = p1_mode_reg;
    assign p1_sum   = p1_sum_reg;

    `ADAS_ASSERT(a_count_range, aclk, aresetn, (count_reg < CNT_W'(SAMPLES)), "round count overran")
    `ADAS_ASSERT_NXT(a_p1_hold, aclk, aresetn, p1_valid_reg && !p2_ready, p1_valid_reg && $stable(p1_sum_reg), "stalled round sum lost")
    `ADAS_ASSERT_IMP(a_ofs_phase, aclk, aresetn, ofs_wr, phase_reg != PH_MEAS, "offset written while measuring")

endmodule

// ===== design/adas_scale.sv =====
// ----------------------------------------------------------------------------
// ADC differential averaging sequencer - scaling pipeline
// Divides calibration and measurement round sums by the sample count, scales alternating
// sums by 4 and measurements by 4/5 with constant reciprocal multipliers; holds the result register.
// ----------------------------------------------------------------------------
module adas_scale import adas_pkg::*; #(
    parameter int SAMPLES     = DEF_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int ACC_W      = SAMPLE_BITS + ACC_GUARD_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          p1_valid,
    input  res_mode_t                     p1_mode,
    input  logic signed [ACC_W-1:0]       p1_sum,
    output logic                          p2_ready,
    output logic                          ofs_wr,
    output logic signed [SAMPLE_BITS-1:0] ofs_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [VALUE_W-1:0]            m_value
);

    // floor(x / SAMPLES) = (x * M1) >> S1 for x < 2**ACC_W
    localparam int S1 = ACC_W + 4;
    localparam logic [S1:0] M1 =
        (S1+1)'(((longint'(1) << S1) + longint'(SAMPLES) - 1) / longint'(SAMPLES));
    // floor(x / 5) = (x * M5) >> S5 for x < 2**X_W
    localparam int X_W = ACC_W + SCALE_SHIFT;
    localparam int S5  = X_W + 3;
    localparam logic [S5:0] M5 =
        (S5+1)'(((longint'(1) << S5) + longint'(ScaleDen) - 1) / longint'(ScaleDen));

    logic [ACC_W-1:0]    mag1, a1, q1;
    logic [ACC_W+S1:0]   prod1;
    logic [VALUE_W-1:0]  val2;

    logic                p2_valid_reg;
    res_mode_t           p2_mode_reg;
    logic [ACC_W-1:0]    p2_mag_reg;
    logic                p2_neg_reg;
    logic [VALUE_W-1:0]  p2_value_reg;

    logic [X_W-1:0]      x3;
    logic [X_W+S5:0]     prod5;
    logic [ACC_W-1:0]    b3, r3;
    logic [VALUE_W-1:0]  val3;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic                out_ready, load2, load3;

    assign out_ready = !out_valid_reg || m_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign load2     = p1_valid && p2_ready;
    assign load3     = p2_valid_reg && out_ready;

    // Stage 2: truncating signed divide by the sample count
    assign mag1  = p1_sum[ACC_W-1] ? ACC_W'(-p1_sum) : ACC_W'(p1_sum);
    assign prod1 = {{(S1+1){1'b0}}, mag1} * {{ACC_W{1'b0}}, M1};
    assign a1    = prod1[S1 +: ACC_W];
    assign q1    = p1_sum[ACC_W-1] ? -a1 : a1;

    always_comb begin
        unique case (p1_mode)
            RES_ALT: val2 = VALUE_W'({p1_sum, {SCALE_SHIFT{1'b0}}});
            RES_CAL: val2 = VALUE_W'(q1[OFFSET_OUT_W-1:0]);
            default: val2 = '0;
        endcase
    end

    assign ofs_wr    = load2 && (p1_mode == RES_CAL);
    assign ofs_value = q1[SAMPLE_BITS-1:0];

    // Stage 3: times 4, truncating divide by 5
    assign x3    = {p2_mag_reg, {SCALE_SHIFT{1'b0}}};
    assign prod5 = {{(S5+1){1'b0}}, x3} * {{X_W{1'b0}}, M5};
    assign b3    = prod5[S5 +: ACC_W];
    assign r3    = p2_neg_reg ? -b3 : b3;
    assign val3  = (p2_mode_reg == RES_MEAS) ? r3[VALUE_W-1:0] : p2_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p2_ready) begin
                p2_valid_reg <= p1_valid;
            end
            if (out_ready) begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            p2_mode_reg  <= p1_mode;
            p2_mag_reg   <= a1;
            p2_neg_reg   <= p1_sum[ACC_W-1];
            p2_value_reg <= val2;
        end
        if (load3) begin
            out_kind_reg  <= (p2_mode_reg == RES_CAL);
            out_value_reg <= val3;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_value = out_value_reg;

endmodule

// ===== design/adc_differential_averaging_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ADC differential averaging sequencer
// Averages converter samples in alternating or gain mode and streams results.
// ----------------------------------------------------------------------------
// One transfer is taken every clock while the result side keeps up. Each
// transfer carries a command or a sample in s_tuser/s_tdata. Start commands
// pick alternating mode (reference/signal pairs, even samples negated, sum
// times 4) or gain mode (skip one sample, average SAMPLES samples into a
// calibration offset and report it with kind 1, skip one more, then average
// offset-corrected rounds forever, scaled by 4/5). Stop idles the block and
// keeps the offset. The transfer of a round's last sample loads the round sum
// register of the accumulate stage; from there the result passes through the
// divide-by-SAMPLES multiplier stage register and then through the 4/5
// multiplier into the output register, from which it is valid on m_tdata.
// Each stage holds when the next is full, so bubbles absorb stalls on the
// result side before input is held back.
// ----------------------------------------------------------------------------
module adc_differential_averaging_sequencer_unit import adas_pkg::*; #(
    parameter int SAMPLES     = DEF_SAMPLES,      // samples per round, 1..15
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS   // used sample width, 8..12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [9:0] sample, [15:10] zero
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [13:0] value, [15:14] zero
    output logic [0:0]          m_tuser    // [0] kind
);

    localparam int ACC_W = SAMPLE_BITS + ACC_GUARD_W;

    // Round sum handed from the accumulate stage to the scaling pipeline
    logic                          p1_valid;
    res_mode_t                     p1_mode;
    logic signed [ACC_W-1:0]       p1_sum;
    logic                          p2_ready;

    // Calibration offset written back when the gain-mode round divides out
    logic                          ofs_wr;
    logic signed [SAMPLE_BITS-1:0] ofs_value;

    logic                          m_kind;
    logic [VALUE_W-1:0]            m_value;

    // Sequence the modes and accumulate one sample per transfer
    adas_accum #(
        .SAMPLES     (SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_op      (op_t'(s_tuser)),
        .s_sample  (s_tdata[SAMPLE_W-1:0]),
        .p2_ready  (p2_ready),
        .ofs_wr    (ofs_wr),
        .ofs_value (ofs_value),
        .p1_valid  (p1_valid),
        .p1_mode   (p1_mode),
        .p1_sum    (p1_sum)
    );

    // Divide, scale and hold the result for the master side
    adas_scale #(
        .SAMPLES     (SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .p1_valid  (p1_valid),
        .p1_mode   (p1_mode),
        .p1_sum    (p1_sum),
        .p2_ready  (p2_ready),
        .ofs_wr    (ofs_wr),
        .ofs_value (ofs_value),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_kind    (m_kind),
        .m_value   (m_value)
    );

    // Pad the value to whole bytes
    assign m_tdata = M_DATA_W'(m_value);
    assign m_tuser = m_kind;

endmodule
